### src/lobm_pkg.sv
`default_nettype none
package lobm_pkg;

    localparam int PRICE_LEVELS = 4096;
    localparam int LVL_W = $clog2(PRICE_LEVELS);
    localparam int PRICE_W = LVL_W + 1;
    localparam int LQ_W = 40;
    localparam int ORD_W = 32;
    localparam int VOL_W = 48;

    localparam logic [LQ_W-1:0] LEVEL_MAX = {LQ_W{1'b1}};
    localparam logic [VOL_W-1:0] VOLUME_MAX = {VOL_W{1'b1}};

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_CLOSE = 1'b1;
    localparam logic SIDE_BUY = 1'b0;
    localparam logic SIDE_SELL = 1'b1;
    localparam logic ORDER_LIMIT = 1'b0;
    localparam logic ORDER_MARKET = 1'b1;
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Request from the sequencer to the bar tracker.
    typedef struct packed {
        logic             fill;
        logic             clear;
        logic [LVL_W-1:0] price;
        logic [ORD_W-1:0] qty;
    } bar_upd_t;

    typedef struct packed {
        logic             has_fill;
        logic [LVL_W-1:0] open_px;
        logic [LVL_W-1:0] high_px;
        logic [LVL_W-1:0] low_px;
        logic [LVL_W-1:0] close_px;
        logic [VOL_W-1:0] volume;
    } bar_t;

endpackage
`default_nettype wire

### src/lobm_ram.sv
`default_nettype none
module lobm_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### src/lobm_bar.sv
`default_nettype none
module lobm_bar
    import lobm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bar_upd_t upd,
    output bar_t          bar
);

    bar_t bar_reg;
    bar_t bar_next;
    logic [VOL_W:0] vol_sum;

    always_comb
    begin
        vol_sum = {1'b0, bar_reg.volume} + (VOL_W + 1)'(upd.qty);
        bar_next = bar_reg;
        if (upd.clear)
        begin
            bar_next = '0;
        end
        else if (upd.fill)
        begin
            if (!bar_reg.has_fill)
            begin
                bar_next.has_fill = 1'b1;
                bar_next.open_px = upd.price;
                bar_next.high_px = upd.price;
                bar_next.low_px = upd.price;
                bar_next.close_px = upd.price;
                bar_next.volume = VOL_W'(upd.qty);
            end
            else
            begin
                if (upd.price > bar_reg.high_px)
                begin
                    bar_next.high_px = upd.price;
                end
                if (upd.price < bar_reg.low_px)
                begin
                    bar_next.low_px = upd.price;
                end
                bar_next.close_px = upd.price;
                bar_next.volume = vol_sum[VOL_W] ? VOLUME_MAX : vol_sum[VOL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_reg <= '0;
        end
        else
        begin
            bar_reg <= bar_next;
        end
    end

    assign bar = bar_reg;

endmodule
`default_nettype wire

### src/limit_order_book_matcher_top.sv
`default_nettype none
// Price-level limit order book with a running open/high/low/close/volume bar.
// Input channel (in_valid/in_ready) carries one transaction per order or
// close-bar request; output channel (out_valid/out_ready) returns exactly one
// result transaction for each input transaction, in order.
// A close-bar or rejected order goes from idle straight to the done state,
// where it is moved to the output register once that register is free.
// A submitted order steps through walk and walk-check for each price level
// walked on the opposite side, rest and, for a limit remainder, rest-check,
// then the best-ask and best-bid resync states for each level stepped over,
// and finally the done state from which its result loads. Typical orders
// touch few levels.
// The pace is set by the read-modify-write loop on the single read port of
// each level memory, whose read data arrives in the cycle after the address.
// One order is in work at a time; the next is accepted once the result has
// been moved to the output register, even while that result still waits.
// After reset the block sweeps both level memories to zero, one level per
// cycle, over all 4096 levels; in_ready stays low during this pass.
// When the receiver stalls, the finished result waits in its sequencer state
// until the output register frees up; nothing is lost.
module limit_order_book_matcher_top
    import lobm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic               side,
    input  wire logic               order_type,
    input  wire logic [PRICE_W-1:0] limit_price,
    input  wire logic [ORD_W-1:0]   order_quantity,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    status,
    output logic [ORD_W-1:0]        filled_quantity,
    output logic [ORD_W-1:0]        rested_quantity,
    output logic [LVL_W-1:0]        best_bid_out,
    output logic [PRICE_W-1:0]      best_ask_out,
    output logic                    bar_valid,
    output logic [LVL_W-1:0]        bar_open_out,
    output logic [LVL_W-1:0]        bar_high_out,
    output logic [LVL_W-1:0]        bar_low_out,
    output logic [LVL_W-1:0]        bar_close_out,
    output logic [VOL_W-1:0]        bar_volume_out
);

    // Sequencer states. Each *_CHK state consumes the read data that the
    // preceding state addressed.
    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b00000000001,
        ST_IDLE     = 11'b00000000010,
        ST_WALK     = 11'b00000000100,
        ST_WALK_CHK = 11'b00000001000,
        ST_REST     = 11'b00000010000,
        ST_REST_CHK = 11'b00000100000,
        ST_RS_A     = 11'b00001000000,
        ST_RS_A_CHK = 11'b00010000000,
        ST_RS_B     = 11'b00100000000,
        ST_RS_B_CHK = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic               op_reg, op_next;
    logic               side_reg, side_next;
    logic               mkt_reg, mkt_next;
    logic [PRICE_W-1:0] limit_reg, limit_next;
    logic [ORD_W-1:0]   qty_reg, qty_next;
    logic [ORD_W-1:0]   rem_reg, rem_next;
    logic [ORD_W-1:0]   filled_reg, filled_next;
    logic [ORD_W-1:0]   rested_reg, rested_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [PRICE_W-1:0] top_ask_reg, top_ask_next;
    logic [LVL_W-1:0]   top_bid_reg, top_bid_next;
    logic               status_reg, status_next;
    logic [LVL_W-1:0]   clr_cnt_reg, clr_cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic               o_status_reg;
    logic [ORD_W-1:0]   o_filled_reg;
    logic [ORD_W-1:0]   o_rested_reg;
    logic [LVL_W-1:0]   o_bid_reg;
    logic [PRICE_W-1:0] o_ask_reg;
    bar_t               o_bar_reg;
    logic               o_load;

    // Memory ports.
    logic               bid_we, ask_we;
    logic [LVL_W-1:0]   wr_addr, rd_addr;
    logic [LQ_W-1:0]    wr_data;
    logic [LQ_W-1:0]    bid_rd, ask_rd;

    bar_upd_t           bar_upd;
    bar_t               bar;

    // Datapath helpers.
    logic [LQ_W-1:0]    opp_rd, own_rd, rem_wide, avail_fill;
    logic [ORD_W-1:0]   fill_qty;
    logic [LQ_W:0]      rest_sum;
    logic               walk_stop;

    lobm_ram #(.WIDTH(LQ_W), .DEPTH(PRICE_LEVELS)) u_bid_ram (
        .clk   (clk),
        .we    (bid_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (bid_rd)
    );

    lobm_ram #(.WIDTH(LQ_W), .DEPTH(PRICE_LEVELS)) u_ask_ram (
        .clk   (clk),
        .we    (ask_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ask_rd)
    );

    lobm_bar u_bar (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (bar_upd),
        .bar   (bar)
    );

    // The walk consumes the opposite side; a remainder rests on its own side.
    assign opp_rd = (side_reg == SIDE_SELL) ? bid_rd : ask_rd;
    assign own_rd = (side_reg == SIDE_SELL) ? ask_rd : bid_rd;
    assign rem_wide = LQ_W'(rem_reg);
    assign avail_fill = (opp_rd >= rem_wide) ? rem_wide : opp_rd;
    assign fill_qty = avail_fill[ORD_W-1:0];
    assign rest_sum = {1'b0, own_rd} + (LQ_W + 1)'(rem_reg);

    // The walk ends on an exhausted order, at level 0, past the top level,
    // or when a limit order crosses its own limit.
    always_comb
    begin
        walk_stop = (rem_reg == '0) || (price_reg == '0) ||
                    (price_reg >= PRICE_W'(PRICE_LEVELS));
        if (mkt_reg == ORDER_LIMIT)
        begin
            if ((side_reg == SIDE_BUY) && (price_reg > limit_reg))
            begin
                walk_stop = 1'b1;
            end
            if ((side_reg == SIDE_SELL) && (price_reg < limit_reg))
            begin
                walk_stop = 1'b1;
            end
        end
    end

    // Read address for the current state; both memories see the same one.
    always_comb
    begin
        unique case (state_reg)
            ST_WALK: rd_addr = price_reg[LVL_W-1:0];
            ST_REST: rd_addr = limit_reg[LVL_W-1:0];
            ST_RS_A: rd_addr = top_ask_reg[LVL_W-1:0];
            ST_RS_B: rd_addr = top_bid_reg;
            default: rd_addr = '0;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign o_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        side_next = side_reg;
        mkt_next = mkt_reg;
        limit_next = limit_reg;
        qty_next = qty_reg;
        rem_next = rem_reg;
        filled_next = filled_reg;
        rested_next = rested_reg;
        price_next = price_reg;
        top_ask_next = top_ask_reg;
        top_bid_next = top_bid_reg;
        status_next = status_reg;
        clr_cnt_next = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        bid_we = 1'b0;
        ask_we = 1'b0;
        wr_addr = price_reg[LVL_W-1:0];
        wr_data = '0;
        bar_upd = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Power-up sweep that empties both sides of the book.
                bid_we = 1'b1;
                ask_we = 1'b1;
                wr_addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {LVL_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = operation;
                    side_next = side;
                    mkt_next = order_type;
                    limit_next = limit_price;
                    qty_next = order_quantity;
                    rem_next = order_quantity;
                    filled_next = '0;
                    rested_next = '0;
                    status_next = STATUS_OK;
                    price_next = (side == SIDE_SELL) ? {1'b0, top_bid_reg} : top_ask_reg;
                    if (operation == OP_CLOSE)
                    begin
                        state_next = ST_DONE;
                    end
                    else if ((order_type == ORDER_LIMIT) &&
                             (limit_price >= PRICE_W'(PRICE_LEVELS)))
                    begin
                        status_next = STATUS_REJECT;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                state_next = walk_stop ? ST_REST : ST_WALK_CHK;
            end
            ST_WALK_CHK:
            begin
                if (opp_rd != '0)
                begin
                    bid_we = (side_reg == SIDE_SELL);
                    ask_we = (side_reg == SIDE_BUY);
                    wr_data = opp_rd - avail_fill;
                    rem_next = rem_reg - fill_qty;
                    filled_next = filled_reg + fill_qty;
                    bar_upd.fill = 1'b1;
                    bar_upd.price = price_reg[LVL_W-1:0];
                    bar_upd.qty = fill_qty;
                end
                price_next = (side_reg == SIDE_SELL) ? price_reg - 1'b1 : price_reg + 1'b1;
                state_next = ST_WALK;
            end
            ST_REST:
            begin
                if ((mkt_reg == ORDER_LIMIT) && (rem_reg != '0))
                begin
                    state_next = ST_REST_CHK;
                end
                else
                begin
                    state_next = ST_RS_A;
                end
            end
            ST_REST_CHK:
            begin
                bid_we = (side_reg == SIDE_BUY);
                ask_we = (side_reg == SIDE_SELL);
                wr_addr = limit_reg[LVL_W-1:0];
                wr_data = rest_sum[LQ_W] ? LEVEL_MAX : rest_sum[LQ_W-1:0];
                rested_next = rem_reg;
                if (side_reg == SIDE_BUY)
                begin
                    if ((top_bid_reg == '0) || (limit_reg > {1'b0, top_bid_reg}))
                    begin
                        top_bid_next = limit_reg[LVL_W-1:0];
                    end
                end
                else
                begin
                    if ((top_ask_reg == PRICE_W'(PRICE_LEVELS)) || (limit_reg < top_ask_reg))
                    begin
                        top_ask_next = limit_reg;
                    end
                end
                state_next = ST_RS_A;
            end
            ST_RS_A:
            begin
                state_next = (top_ask_reg >= PRICE_W'(PRICE_LEVELS)) ? ST_RS_B : ST_RS_A_CHK;
            end
            ST_RS_A_CHK:
            begin
                if (ask_rd == '0)
                begin
                    top_ask_next = top_ask_reg + 1'b1;
                    state_next = ST_RS_A;
                end
                else
                begin
                    state_next = ST_RS_B;
                end
            end
            ST_RS_B:
            begin
                state_next = (top_bid_reg == '0) ? ST_DONE : ST_RS_B_CHK;
            end
            ST_RS_B_CHK:
            begin
                if (bid_rd == '0)
                begin
                    top_bid_next = top_bid_reg - 1'b1;
                    state_next = ST_RS_B;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // The bar is reported first and cleared in the same cycle.
                if (o_load)
                begin
                    out_valid_next = 1'b1;
                    bar_upd.clear = (op_reg == OP_CLOSE);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            top_ask_reg <= PRICE_W'(PRICE_LEVELS);
            top_bid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            top_ask_reg <= top_ask_next;
            top_bid_reg <= top_bid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        side_reg <= side_next;
        mkt_reg <= mkt_next;
        limit_reg <= limit_next;
        qty_reg <= qty_next;
        rem_reg <= rem_next;
        filled_reg <= filled_next;
        rested_reg <= rested_next;
        price_reg <= price_next;
        status_reg <= status_next;
        if (o_load)
        begin
            o_status_reg <= status_reg;
            o_filled_reg <= filled_reg;
            o_rested_reg <= rested_reg;
            o_bid_reg <= top_bid_reg;
            o_ask_reg <= top_ask_reg;
            o_bar_reg <= bar;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = o_status_reg;
    assign filled_quantity = o_filled_reg;
    assign rested_quantity = o_rested_reg;
    assign best_bid_out = o_bid_reg;
    assign best_ask_out = o_ask_reg;
    assign bar_valid = o_bar_reg.has_fill;
    assign bar_open_out = o_bar_reg.open_px;
    assign bar_high_out = o_bar_reg.high_px;
    assign bar_low_out = o_bar_reg.low_px;
    assign bar_close_out = o_bar_reg.close_px;
    assign bar_volume_out = o_bar_reg.volume;

    // No result may appear while the book is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
    else $error("result presented during the clearing pass");

    // The best ask never points past the no-ask marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        top_ask_reg <= PRICE_W'(PRICE_LEVELS))
    else $error("best ask beyond the top level");

    // A level is only examined while the order still has quantity left.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_CHK) |-> (rem_reg != '0))
    else $error("level examined with nothing left to fill");

    // During the walk, filled plus remaining always equals the order size.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) || (state_reg == ST_WALK_CHK)) |->
        (({1'b0, filled_reg} + {1'b0, rem_reg}) == {1'b0, qty_reg}))
    else $error("fill accounting lost quantity");

endmodule
`default_nettype wire
